>>> design/mlfq_pkg.sv
// Package for the multilevel feedback queue scheduler: sizes, command codes
// and the result record. Used by mlfq_scheduler_queues and the testbench.
package mlfq_pkg;

    localparam int LEVELS    = 4;
    localparam int TASKS     = 16;
    localparam int TIME_BITS = 32;

    localparam int LVW   = $clog2(LEVELS);
    localparam int TW    = $clog2(TASKS);
    localparam int CW    = $clog2(TASKS + 1);
    localparam int RAW   = LVW + TW;

    localparam logic [2:0] F_PUSH_RDY = 3'd0;
    localparam logic [2:0] F_PUSH_BLK = 3'd1;
    localparam logic [2:0] F_POP_RDY  = 3'd2;
    localparam logic [2:0] F_AGE      = 3'd3;
    localparam logic [2:0] F_FIND_BLK = 3'd4;
    localparam logic [2:0] F_FIND_RDY = 3'd5;
    localparam logic [2:0] F_SET_FLAG = 3'd6;

    localparam logic [15:0] AGE_MAX = 16'sh7fff;
    localparam logic [15:0] AGE_MIN = 16'sh8000;
    localparam logic [18:0] QUANT_MAX = 19'h7ffff;

    typedef struct packed {
        logic        found;
        logic [1:0]  level_out;
        logic [3:0]  task_out;
        logic [18:0] quantum;
        logic [3:0]  merged_levels;
        logic [4:0]  moved_count;
        logic        overflow;
    } t_result;

endpackage

>>> design/mlfq_scheduler_queues.sv
// Multilevel feedback queue scheduler. One command per item, one result per
// item. Queue slots, blocked slots and wake times live in synchronous RAMs
// with registered reads; the sequencer handles one command at a time and
// takes no new item until the last one's result is registered. Find ready
// examines levels in turn from level 0; age checks each level above level 0
// and moves the tasks of a merged level one at a time; find blocked examines
// blocked entries in turn. A result held by i_stall holds off the next item.
// Depends on mlfq_pkg and mlfq_ram.
module mlfq_scheduler_queues
    import mlfq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [1:0]  i_level,
    input  logic [3:0]  i_task_req,
    input  logic [31:0] i_wake_at,
    input  logic [31:0] i_now,
    input  logic        i_ready_flag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [1:0]  o_level_out,
    output logic [3:0]  o_task_out,
    output logic [18:0] o_quantum,
    output logic [3:0]  o_merged_levels,
    output logic [4:0]  o_moved_count,
    output logic        o_overflow,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;  // ready slot read in flight
    localparam logic [3:0] S_FRWT  = 4'd2;  // find ready: data valid
    localparam logic [3:0] S_AGEL  = 4'd3;  // age: check level
    localparam logic [3:0] S_AGEW  = 4'd4;  // age: move read wait
    localparam logic [3:0] S_AGEM  = 4'd5;  // age: move write
    localparam logic [3:0] S_BRD   = 4'd6;  // blocked slot read
    localparam logic [3:0] S_BWK   = 4'd7;  // wake time read
    localparam logic [3:0] S_BCMP  = 4'd8;  // compare
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_POPD  = 4'd10;

    logic [3:0]           r_state;
    logic [15:0]          r_base_q;
    logic [7:0]           r_max_age;
    logic [TW-1:0]        r_head  [LEVELS];
    logic [CW-1:0]        r_count [LEVELS];
    logic [15:0]          r_age   [LEVELS];
    logic [TW-1:0]        r_bhead;
    logic [CW-1:0]        r_bcount;
    logic [TASKS-1:0]     r_flag;
    logic [2:0]           r_func;
    logic [TIME_BITS-1:0] r_now;
    logic [LVW:0]         r_i;
    logic [CW-1:0]        r_n;
    logic [TW-1:0]        r_bt;
    t_result              r_res;
    logic                 r_ovalid;

    // memory ports
    logic                 rs_we;
    logic [RAW-1:0]       rs_wa, rs_ra;
    logic [TW-1:0]        rs_wd, rs_rd;
    logic                 bs_we;
    logic [TW-1:0]        bs_wa, bs_ra, bs_wd, bs_rd;
    logic                 wk_we;
    logic [TW-1:0]        wk_wa, wk_ra;
    logic [TIME_BITS-1:0] wk_wd, wk_rd;

    mlfq_ram #(.WIDTH(TW), .DEPTH(LEVELS*TASKS)) u_rslots (
        .i_clk, .i_we(rs_we), .i_waddr(rs_wa), .i_wdata(rs_wd),
        .i_raddr(rs_ra), .o_rdata(rs_rd));
    mlfq_ram #(.WIDTH(TW), .DEPTH(TASKS)) u_bslots (
        .i_clk, .i_we(bs_we), .i_waddr(bs_wa), .i_wdata(bs_wd),
        .i_raddr(bs_ra), .o_rdata(bs_rd));
    mlfq_ram #(.WIDTH(TIME_BITS), .DEPTH(TASKS)) u_wake (
        .i_clk, .i_we(wk_we), .i_waddr(wk_wa), .i_wdata(wk_wd),
        .i_raddr(wk_ra), .o_rdata(wk_rd));

    logic           accept;
    logic [LVW-1:0] cur, below;
    logic [TW-1:0]  tail_below;
    logic           do_merge;
    logic [18:0]    quant_calc;
    logic [20:0]    qprod;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign cur     = r_i[LVW-1:0];
    assign below   = LVW'(r_i - 1'b1);
    assign tail_below = TW'(r_head[below] + TW'(r_count[below]));
    assign do_merge = (r_count[cur] != '0) &&
                      ($signed(r_age[cur]) > $signed({8'd0, r_max_age}));
    assign qprod = 21'(r_base_q) * 21'({cur, 1'b0});
    assign quant_calc = (cur == '0) ? 19'(r_base_q) :
                        (qprod > 21'(QUANT_MAX)) ? QUANT_MAX : qprod[18:0];

    // memory addresses and writes
    always_comb begin
        rs_we = 1'b0; rs_wa = '0; rs_wd = '0;
        rs_ra = {cur, r_head[cur]};
        bs_we = 1'b0; bs_wa = '0; bs_wd = r_bt;
        bs_ra = r_bhead;
        wk_we = 1'b0; wk_wa = i_task_req; wk_wd = i_wake_at;
        wk_ra = bs_rd;
        if (accept && i_func == F_PUSH_RDY && r_count[i_level] != CW'(TASKS)) begin
            rs_we = 1'b1;
            rs_wa = {i_level, TW'(r_head[i_level] + TW'(r_count[i_level]))};
            rs_wd = i_task_req;
        end
        if (accept && i_func == F_PUSH_BLK && r_bcount != CW'(TASKS)) begin
            bs_we = 1'b1;
            bs_wa = TW'(r_bhead + TW'(r_bcount));
            bs_wd = i_task_req;
            wk_we = 1'b1;
        end
        if (r_state == S_AGEM) begin
            rs_we = 1'b1;
            rs_wa = {below, tail_below};
            rs_wd = rs_rd;
        end
        if (r_state == S_BCMP && !(r_now >= wk_rd)) begin
            bs_we = 1'b1;
            bs_wa = TW'(r_bhead + TW'(r_bcount));
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_bhead  <= '0;
            r_bcount <= '0;
            r_flag   <= '0;
            r_base_q <= 16'd1000;
            r_max_age <= 8'd5;
            for (int k = 0; k < LEVELS; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
                r_age[k]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == 1'b0) r_base_q  <= i_cfg_wdata;
                else                    r_max_age <= i_cfg_wdata[7:0];
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func <= i_func;
                        r_now  <= i_now;
                        r_res  <= '0;
                        r_i    <= '0;
                        r_state <= S_DONE;
                        case (i_func)
                            F_PUSH_RDY: begin
                                if (r_count[i_level] == CW'(TASKS))
                                    r_res.overflow <= 1'b1;
                                else r_count[i_level] <= r_count[i_level] + 1'b1;
                            end
                            F_PUSH_BLK: begin
                                if (r_bcount == CW'(TASKS)) r_res.overflow <= 1'b1;
                                else r_bcount <= r_bcount + 1'b1;
                            end
                            F_POP_RDY: begin
                                if (r_count[i_level] != '0) begin
                                    r_i <= {1'b0, i_level};
                                    r_state <= S_POPD;
                                end
                            end
                            F_AGE: begin
                                for (int k = 0; k < LEVELS; k++) begin
                                    logic [15:0] a;
                                    a = (r_age[k] == AGE_MAX) ? r_age[k] : r_age[k] + 1'b1;
                                    if (LVW'(k) == i_level)
                                        a = ($signed(a) < $signed(AGE_MIN + 16'd2)) ?
                                            AGE_MIN : a - 16'd2;
                                    r_age[k] <= a;
                                end
                                r_i <= (LVW+1)'(1);
                                r_state <= S_AGEL;
                            end
                            F_FIND_BLK: begin
                                r_n <= r_bcount;
                                if (r_bcount != '0) r_state <= S_BRD;
                            end
                            F_FIND_RDY: r_state <= S_RD;
                            F_SET_FLAG: r_flag[i_task_req] <= i_ready_flag;
                            default: ;
                        endcase
                    end
                end
                S_POPD: r_state <= S_RD;
                S_RD: begin
                    if (r_func == F_POP_RDY) begin
                        r_res.found <= 1'b1;
                        r_res.task_out <= rs_rd;
                        r_head[cur] <= r_head[cur] + 1'b1;
                        r_count[cur] <= r_count[cur] - 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_FRWT;
                    end
                end
                S_FRWT: begin
                    if (r_count[cur] != '0 && r_flag[rs_rd]) begin
                        r_res.found <= 1'b1;
                        r_res.level_out <= cur;
                        r_res.task_out <= rs_rd;
                        r_res.quantum <= quant_calc;
                        r_state <= S_DONE;
                    end else if (r_i == (LVW+1)'(LEVELS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_AGEL: begin
                    if (r_i == (LVW+1)'(LEVELS)) begin
                        r_state <= S_DONE;
                    end else if (do_merge) begin
                        r_res.merged_levels[cur] <= 1'b1;
                        r_state <= S_AGEW;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_AGEW: begin
                    if (r_count[cur] != '0 && r_count[below] != CW'(TASKS)) begin
                        r_state <= S_AGEM;
                    end else begin
                        r_age[cur] <= '0;
                        r_i <= r_i + 1'b1;
                        r_state <= S_AGEL;
                    end
                end
                S_AGEM: begin
                    r_head[cur]    <= r_head[cur] + 1'b1;
                    r_count[cur]   <= r_count[cur] - 1'b1;
                    r_count[below] <= r_count[below] + 1'b1;
                    if (r_res.moved_count != 5'd31)
                        r_res.moved_count <= r_res.moved_count + 1'b1;
                    r_state <= S_AGEW;
                end
                S_BRD: r_state <= S_BWK;
                S_BWK: begin
                    r_bt <= bs_rd;
                    r_state <= S_BCMP;
                end
                S_BCMP: begin
                    r_bhead <= r_bhead + 1'b1;
                    r_n <= r_n - 1'b1;
                    if (r_now >= wk_rd) begin
                        r_bcount <= r_bcount - 1'b1;
                        r_res.found <= 1'b1;
                        r_res.task_out <= r_bt;
                        r_state <= S_DONE;
                    end else if (r_n == CW'(1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_BRD;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_found = r_res.found;
    assign o_level_out = r_res.level_out;
    assign o_task_out = r_res.task_out;
    assign o_quantum = r_res.quantum;
    assign o_merged_levels = r_res.merged_levels;
    assign o_moved_count = r_res.moved_count;
    assign o_overflow = r_res.overflow;
endmodule

>>> design/mlfq_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
module mlfq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write, then registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> tb/tb_mlfq_scheduler_queues.sv
// Self-checking testbench for mlfq_scheduler_queues: random and directed scheduler
// commands, checked against an in-bench model of the ready, blocked and age state.
// Depends on mlfq_pkg and the design folder only.
module tb_mlfq_scheduler_queues;
    import mlfq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REG_BASE_QUANTUM = 1'b0;
    localparam logic REG_MAX_AGE      = 1'b1;
    localparam int   STALL_LIMIT      = 20000;
    localparam int   DRAIN_CYCLES     = 60;
    localparam int   AGE_HI           = 32767;
    localparam int   AGE_LO           = -32768;

    typedef struct {
        logic [2:0]  func;
        logic [1:0]  lvl;
        logic [3:0]  tsk;
        logic [31:0] wake;
        logic [31:0] now;
        logic        flag;
    } t_sched_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_func = '0;
    logic [1:0]  i_level = '0;
    logic [3:0]  i_task_req = '0;
    logic [31:0] i_wake_at = '0;
    logic [31:0] i_now = '0;
    logic        i_ready_flag = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_found;
    logic [1:0]  o_level_out;
    logic [3:0]  o_task_out;
    logic [18:0] o_quantum;
    logic [3:0]  o_merged_levels;
    logic [4:0]  o_moved_count;
    logic        o_overflow;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    mlfq_scheduler_queues uut (.*);

    // scheduler shadow state
    logic [3:0]  rq_slot [LEVELS][TASKS];
    int          rq_head [LEVELS];
    int          rq_cnt  [LEVELS];
    int          lvl_age [LEVELS];
    logic [3:0]  bq_slot [TASKS];
    int          bq_head;
    int          bq_cnt;
    logic [31:0] wake_tab [TASKS];
    logic        rdy_tab  [TASKS];
    int          base_quantum;
    int          max_age;

    t_sched_cmd  pend_q[$];
    t_result     result_q[$];
    int          err_cnt = 0;
    int          tx_idle = 0;
    int          rx_idle = 0;
    int          quiet_cycles = 0;

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void rq_put(int lv, logic [3:0] t);
        rq_slot[lv][(rq_head[lv] + rq_cnt[lv]) % TASKS] = t;
        rq_cnt[lv]++;
    endfunction

    function automatic logic [3:0] rq_take(int lv);
        logic [3:0] t;
        t = rq_slot[lv][rq_head[lv]];
        rq_head[lv] = (rq_head[lv] + 1) % TASKS;
        rq_cnt[lv]--;
        return t;
    endfunction

    function automatic void bq_put(logic [3:0] t);
        bq_slot[(bq_head + bq_cnt) % TASKS] = t;
        bq_cnt++;
    endfunction

    function automatic logic [3:0] bq_take();
        logic [3:0] t;
        t = bq_slot[bq_head];
        bq_head = (bq_head + 1) % TASKS;
        bq_cnt--;
        return t;
    endfunction

    // apply one command to the shadow state and return the scheduler's answer
    function automatic t_result sched_step(t_sched_cmd c);
        t_result    r;
        int         n;
        int         moved;
        int         lv;
        logic [3:0] t;
        longint     q;
        r = '0;
        lv = int'(c.lvl);
        moved = 0;
        case (c.func)
            F_PUSH_RDY: begin
                if (rq_cnt[lv] >= TASKS) r.overflow = 1'b1;
                else rq_put(lv, c.tsk);
            end
            F_PUSH_BLK: begin
                if (bq_cnt >= TASKS) begin
                    r.overflow = 1'b1;
                end else begin
                    wake_tab[c.tsk] = c.wake;
                    bq_put(c.tsk);
                end
            end
            F_POP_RDY: begin
                if (rq_cnt[lv] > 0) begin
                    r.found = 1'b1;
                    r.task_out = rq_take(lv);
                end
            end
            F_AGE: begin
                for (int i = 0; i < LEVELS; i++)
                    if (lvl_age[i] < AGE_HI) lvl_age[i]++;
                lvl_age[lv] -= 2;
                if (lvl_age[lv] < AGE_LO) lvl_age[lv] = AGE_LO;
                // merge starving levels one step up, as far as room allows
                for (int i = 1; i < LEVELS; i++) begin
                    if (rq_cnt[i] != 0 && lvl_age[i] > max_age) begin
                        while (rq_cnt[i] > 0 && rq_cnt[i-1] < TASKS) begin
                            rq_put(i - 1, rq_take(i));
                            moved++;
                        end
                        lvl_age[i] = 0;
                        r.merged_levels[i] = 1'b1;
                    end
                end
                r.moved_count = (moved > 31) ? 5'd31 : 5'(moved);
            end
            F_FIND_BLK: begin
                n = bq_cnt;
                for (int i = 0; i < n; i++) begin
                    t = bq_take();
                    if (c.now >= wake_tab[t]) begin
                        r.found = 1'b1;
                        r.task_out = t;
                        break;
                    end
                    bq_put(t);
                end
            end
            F_FIND_RDY: begin
                for (int i = 0; i < LEVELS; i++) begin
                    if (rq_cnt[i] > 0 && rdy_tab[rq_slot[i][rq_head[i]]]) begin
                        r.found = 1'b1;
                        r.level_out = 2'(i);
                        r.task_out = rq_slot[i][rq_head[i]];
                        q = (i == 0) ? longint'(base_quantum) :
                                       longint'(2 * i * base_quantum);
                        r.quantum = (q > QUANT_MAX) ? QUANT_MAX : 19'(q);
                        break;
                    end
                end
            end
            F_SET_FLAG: rdy_tab[c.tsk] = c.flag;
            default: ;
        endcase
        return r;
    endfunction

    function automatic void field_chk(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // driver: predict each accepted item, then present the next one
    always @(posedge i_clk) begin : drive_items
        t_sched_cmd cur;
        t_sched_cmd nx;
        logic       take;
        take = i_valid && !o_stall;
        if (take) begin
            cur.func = i_func; cur.lvl = i_level; cur.tsk = i_task_req;
            cur.wake = i_wake_at; cur.now = i_now; cur.flag = i_ready_flag;
            result_q.push_back(sched_step(cur));
        end
        if (i_rst_n && (!i_valid || take)) begin
            if (pend_q.size() > 0 && $urandom_range(0, 99) >= tx_idle) begin
                nx = pend_q.pop_front();
                i_func <= nx.func; i_level <= nx.lvl; i_task_req <= nx.tsk;
                i_wake_at <= nx.wake; i_now <= nx.now; i_ready_flag <= nx.flag;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: check each accepted result against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result e;
        if (o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got task %0d",
                         $time, o_task_out);
                err_cnt++;
            end else begin
                e = result_q.pop_front();
                field_chk("found", e.found, o_found);
                field_chk("level_out", e.level_out, o_level_out);
                field_chk("task_out", e.task_out, o_task_out);
                field_chk("quantum", e.quantum, o_quantum);
                field_chk("merged_levels", e.merged_levels, o_merged_levels);
                field_chk("moved_count", e.moved_count, o_moved_count);
                field_chk("overflow", e.overflow, o_overflow);
            end
        end
        i_stall <= i_rst_n && ($urandom_range(0, 99) < rx_idle);
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_cmd(logic [2:0] f, logic [1:0] l, logic [3:0] t,
                           logic [31:0] w, logic [31:0] n, logic fl);
        t_sched_cmd c;
        c.func = f; c.lvl = l; c.tsk = t; c.wake = w; c.now = n; c.flag = fl;
        pend_q.push_back(c);
    endtask

    task automatic cfg_write(logic idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        if (idx == REG_BASE_QUANTUM) base_quantum = int'(val);
        else max_age = int'(val[7:0]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // hold off until the block has answered everything
    task automatic wait_idle();
        wait (pend_q.size() == 0 && !i_valid && result_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic gen_random(int count);
        int          added;
        int          k;
        logic [1:0]  lv;
        logic [31:0] t0;
        added = 0;
        while (added < count) begin
            k = $urandom_range(0, 19);
            lv = 2'($urandom_range(0, 3));
            t0 = $urandom;
            if (k < 6) begin
                // noise: any field pattern, any function code
                add_cmd(3'($urandom_range(0, 7)), lv, 4'($urandom), $urandom, $urandom,
                        1'($urandom));
                added++;
            end else if (k < 10) begin
                // ready burst: push, mark, look up, take some back
                for (int i = 0; i < 5; i++) begin
                    add_cmd(F_PUSH_RDY, lv, 4'($urandom), 0, 0, 0);
                    add_cmd(F_SET_FLAG, 0, 4'($urandom), 0, 0, 1'($urandom));
                end
                add_cmd(F_FIND_RDY, 0, 0, 0, 0, 0);
                for (int i = 0; i < 3; i++) add_cmd(F_POP_RDY, 2'($urandom), 0, 0, 0, 0);
                add_cmd(F_FIND_RDY, 0, 0, 0, 0, 0);
                added += 15;
            end else if (k < 13) begin
                // blocked burst with wake times close to now
                for (int i = 0; i < 4; i++)
                    add_cmd(F_PUSH_BLK, 0, 4'($urandom), t0 + $urandom_range(0, 100), 0, 0);
                for (int i = 0; i < 4; i++)
                    add_cmd(F_FIND_BLK, 0, 0, 0, t0 + $urandom_range(0, 120), 0);
                added += 8;
            end else if (k < 16) begin
                for (int i = 0; i < 3; i++) add_cmd(F_AGE, 2'($urandom), 0, 0, 0, 0);
                add_cmd(F_FIND_RDY, 0, 0, 0, 0, 0);
                added += 4;
            end else if (k < 18) begin
                // drain one level past empty
                for (int i = 0; i < 17; i++) add_cmd(F_POP_RDY, lv, 0, 0, 0, 0);
                added += 17;
            end else if (k == 18) begin
                // flood the lower levels past full, then age to force big merges
                for (int l = 1; l < LEVELS; l++)
                    for (int i = 0; i <= TASKS; i++)
                        add_cmd(F_PUSH_RDY, 2'(l), 4'($urandom), 0, 0, 0);
                add_cmd(F_AGE, 0, 0, 0, 0, 0);
                add_cmd(F_AGE, 0, 0, 0, 0, 0);
                added += 3 * (TASKS + 1) + 2;
            end else begin
                // fill and empty the blocked queue
                for (int i = 0; i <= TASKS; i++)
                    add_cmd(F_PUSH_BLK, 0, 4'($urandom), $urandom, 0, 0);
                for (int i = 0; i < 6; i++) add_cmd(F_FIND_BLK, 0, 0, 0, $urandom, 0);
                for (int i = 0; i < TASKS; i++) add_cmd(F_FIND_BLK, 0, 0, 0, '1, 0);
                added += TASKS + 1 + 6 + TASKS;
            end
        end
    endtask

    initial begin
        for (int l = 0; l < LEVELS; l++) begin
            rq_head[l] = 0; rq_cnt[l] = 0; lvl_age[l] = 0;
            for (int i = 0; i < TASKS; i++) rq_slot[l][i] = '0;
        end
        for (int i = 0; i < TASKS; i++) begin
            bq_slot[i] = '0; wake_tab[i] = '0; rdy_tab[i] = 1'b0;
        end
        bq_head = 0; bq_cnt = 0;
        base_quantum = 1000;
        max_age = 5;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase one: sender idles lightly, receiver heavily
        tx_idle = 17; rx_idle = 88;
        cfg_write(REG_BASE_QUANTUM, 16'hffff);
        cfg_write(REG_MAX_AGE, 16'd0);
        // directed corners
        add_cmd(F_FIND_RDY, 0, 0, 0, 0, 0);
        add_cmd(F_POP_RDY, 0, 0, 0, 0, 0);
        add_cmd(F_FIND_BLK, 0, 0, 0, '1, 0);
        add_cmd(F_PUSH_RDY, 0, 0, 0, 0, 0);
        add_cmd(F_PUSH_RDY, 3, 4'hf, 0, 0, 0);
        add_cmd(F_SET_FLAG, 0, 4'hf, 0, 0, 1'b1);
        add_cmd(F_FIND_RDY, 0, 0, 0, 0, 0);
        add_cmd(F_SET_FLAG, 0, 4'h0, 0, 0, 1'b1);
        add_cmd(F_FIND_RDY, 0, 0, 0, 0, 0);
        add_cmd(F_POP_RDY, 0, 0, 0, 0, 0);
        add_cmd(F_FIND_RDY, 0, 0, 0, 0, 0);
        add_cmd(F_PUSH_BLK, 0, 4'h7, '1, 0, 0);
        add_cmd(F_PUSH_BLK, 0, 4'h2, 32'd0, 0, 0);
        add_cmd(F_FIND_BLK, 0, 0, 0, 32'd0, 0);
        add_cmd(F_FIND_BLK, 0, 0, 0, 32'hfffffffe, 0);
        add_cmd(F_FIND_BLK, 0, 0, 0, '1, 0);
        add_cmd(3'd7, 2'd3, 4'hf, '1, '1, 1'b1);
        add_cmd(F_PUSH_RDY, 2, 4'h5, 0, 0, 0);
        add_cmd(F_AGE, 0, 0, 0, 0, 0);
        add_cmd(F_AGE, 3, 0, 0, 0, 0);
        add_cmd(F_POP_RDY, 1, 0, 0, 0, 0);
        add_cmd(F_SET_FLAG, 0, 4'hf, 0, 0, 1'b0);
        gen_random(500);
        wait_idle();

        // phase two: roles swapped
        tx_idle = 88; rx_idle = 17;
        cfg_write(REG_BASE_QUANTUM, 16'd1);
        cfg_write(REG_MAX_AGE, 16'd255);
        gen_random(500);
        wait_idle();

        // phase three: no idling
        tx_idle = 0; rx_idle = 0;
        cfg_write(REG_BASE_QUANTUM, 16'($urandom_range(2, 65534)));
        cfg_write(REG_MAX_AGE, 16'($urandom_range(1, 12)));
        gen_random(500);
        wait_idle();

        // long aging run on one level, then merge and lookup checks
        cfg_write(REG_MAX_AGE, 16'd255);
        for (int i = 0; i < 60; i++) add_cmd(F_AGE, 1, 0, 0, 0, 0);
        add_cmd(F_PUSH_RDY, 1, 4'h9, 0, 0, 0);
        add_cmd(F_AGE, 1, 0, 0, 0, 0);
        add_cmd(F_AGE, 2, 0, 0, 0, 0);
        add_cmd(F_FIND_RDY, 0, 0, 0, 0, 0);
        wait_idle();

        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
